// ===== hw/rtl/css_pkg.sv =====
// Shared constants, types and helper functions for the canon score sequencer.
// No dependencies; imported by every module of the block.
package css_pkg;

  // Score and canon geometry
  localparam int SCORE_DEPTH         = 64;
  localparam int SLOTS_PER_MEASURE_P = 8;
  localparam int MEASURE_COUNT       = 8;
  localparam int DEG_PER_MEASURE     = 45;
  localparam int LAG_SECOND          = 16;
  localparam int LAG_THIRD           = 32;
  // 60000 ms per minute, half a beat per note
  localparam int HALF_BEAT_MS        = 30000;
  localparam int TIMEOUT_RST         = 300;

  // Field widths
  localparam int PITCH_W = 7;
  localparam int ANGLE_W = 9;
  localparam int BPM_W   = 9;
  localparam int VOL_W   = 8;
  localparam int FX_W    = 8;
  localparam int TIME_W  = 32;
  localparam int ENTRY_W = 6;
  localparam int DUR_W   = 15;
  localparam int MOUT_W  = 4;
  localparam int LEN_W   = 7;
  localparam int TMO_W   = 16;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  // Derived widths
  localparam int ADDR_W  = (SCORE_DEPTH > 1) ? $clog2(SCORE_DEPTH) : 1;
  localparam int IDX_MAX = ((SCORE_DEPTH + LAG_THIRD) > ((MEASURE_COUNT - 1) * SLOTS_PER_MEASURE_P))
                         ? (SCORE_DEPTH + LAG_THIRD)
                         : ((MEASURE_COUNT - 1) * SLOTS_PER_MEASURE_P);
  localparam int IDX_W   = $clog2(IDX_MAX + 1);
  localparam int MEAS_W  = (MEASURE_COUNT > 1) ? $clog2(MEASURE_COUNT) : 1;
  localparam int DIV_STEPS = DUR_W;
  localparam int DCNT_W  = $clog2(DIV_STEPS);

  // Register index decoded from paddr[2]
  localparam logic APB_REG_SCORE_LEN = 1'b0;
  localparam logic APB_REG_TIMEOUT   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_RD_LEAD,
    ST_RD_SECOND,
    ST_RD_THIRD,
    ST_RD_LAST,
    ST_WAIT_DIV,
    ST_EMIT
  } ctrl_state_e;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_SCRUB  = 2'd1,
    KIND_NOTE   = 2'd2,
    KIND_END    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    VOICE_LEAD,
    VOICE_SECOND,
    VOICE_THIRD
  } voice_e;

  typedef struct packed {
    logic   capture;
    logic   wr_mem;
    logic   eval;
    voice_e rd_sel;
    logic   cap_lead;
    logic   cap_second;
    logic   cap_third;
    logic   commit;
    logic   load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic is_write;
    logic is_note;
    logic div_done;
    logic out_free;
  } dp_status_t;

  typedef struct packed {
    logic [LEN_W-1:0] score_length;
    logic [TMO_W-1:0] release_timeout_ms;
  } cfg_t;

  // Knob angle to measure: count of measure boundaries passed, capped by construction
  function automatic logic [MEAS_W-1:0] measure_of_angle(input logic [ANGLE_W-1:0] angle);
    logic [MEAS_W-1:0] m;
    m = '0;
    for (int k = 1; k < MEASURE_COUNT; k++) begin
      if (32'(angle) >= k * DEG_PER_MEASURE) m = m + 1'b1;
    end
    return m;
  endfunction

  // Score index to displayed measure, 1-based, capped at MEASURE_COUNT
  function automatic logic [MOUT_W-1:0] measure_of_index(input logic [IDX_W-1:0] idx);
    logic [MOUT_W-1:0] m;
    m = MOUT_W'(1);
    for (int k = 1; k < MEASURE_COUNT; k++) begin
      if (32'(idx) >= k * SLOTS_PER_MEASURE_P) m = m + 1'b1;
    end
    return m;
  endfunction

endpackage

// ===== hw/rtl/canon_score_sequencer_with_scrub.sv =====
// Three-voice canon sequencer with measure scrubbing: top level.
// Holds the APB configuration registers; depends on css_pkg, css_ctrl, css_dp.
//
// Input channel (in_valid_i/in_ready_o): a write beat (req_type_i = 1) stores
// one pitch in the score memory and produces no result; an update beat
// (req_type_i = 0) produces exactly one result beat on the output channel
// (out_valid_o/out_ready_i): status, scrub rest, note triple or end all-off.
// Items are processed one at a time. A note update waits for the 15-step
// restoring divider that forms 30000/bpm (the three voice reads run alongside
// it on the single score memory read port).
// The output register lets a new beat be accepted while a result waits; a
// stalled receiver stalls the next result hand-off and new beats with it.
// Reset clears the sequencer state, sets score_length to 0 and the release
// timeout to 300 ms. Score memory contents are undefined until written.
// Registers: 0x0 score_length, 0x4 release_timeout_ms; write only when idle.
module canon_score_sequencer_with_scrub (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        req_type_i,
  input  logic [css_pkg::ANGLE_W-1:0] angle_i,
  input  logic [css_pkg::BPM_W-1:0]   bpm_i,
  input  logic [css_pkg::VOL_W-1:0]   volume_i,
  input  logic [css_pkg::FX_W-1:0]    effects_i,
  input  logic [css_pkg::TIME_W-1:0]  current_time_i,
  input  logic                        playing_in_i,
  input  logic [css_pkg::ENTRY_W-1:0] entry_index_i,
  input  logic [css_pkg::PITCH_W-1:0] entry_pitch_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  kind_o,
  output logic [css_pkg::PITCH_W-1:0] pitch_lead_o,
  output logic [css_pkg::PITCH_W-1:0] pitch_second_o,
  output logic [css_pkg::PITCH_W-1:0] pitch_third_o,
  output logic [css_pkg::VOL_W-1:0]   out_volume_o,
  output logic [css_pkg::FX_W-1:0]    out_effects_o,
  output logic [css_pkg::DUR_W-1:0]   duration_ms_o,
  output logic [css_pkg::MOUT_W-1:0]  measure_o,
  output logic                        playing_out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [css_pkg::APB_AW-1:0]  paddr,
  input  logic [css_pkg::APB_DW-1:0]  pwdata,
  output logic [css_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import css_pkg::*;

  logic [LEN_W-1:0] score_length_q;
  logic [TMO_W-1:0] timeout_q;
  logic             apb_wr;
  cfg_t             cfg;
  dp_cmd_t          cmd;
  dp_status_t       st;

  assign pready = 1'b1;
  assign apb_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      score_length_q <= '0;
      timeout_q      <= TMO_W'(TIMEOUT_RST);
    end else if (apb_wr) begin
      case (paddr[2])
        APB_REG_SCORE_LEN: score_length_q <= pwdata[LEN_W-1:0];
        APB_REG_TIMEOUT:   timeout_q      <= pwdata[TMO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      APB_REG_SCORE_LEN: prdata = APB_DW'(score_length_q);
      APB_REG_TIMEOUT:   prdata = APB_DW'(timeout_q);
      default:           prdata = '0;
    endcase
  end

  assign cfg.score_length       = score_length_q;
  assign cfg.release_timeout_ms = timeout_q;

  css_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  css_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_type_i     (req_type_i),
    .angle_i        (angle_i),
    .bpm_i          (bpm_i),
    .volume_i       (volume_i),
    .effects_i      (effects_i),
    .current_time_i (current_time_i),
    .playing_in_i   (playing_in_i),
    .entry_index_i  (entry_index_i),
    .entry_pitch_i  (entry_pitch_i),
    .cfg_i          (cfg),
    .cmd_i          (cmd),
    .st_o           (st),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .kind_o         (kind_o),
    .pitch_lead_o   (pitch_lead_o),
    .pitch_second_o (pitch_second_o),
    .pitch_third_o  (pitch_third_o),
    .out_volume_o   (out_volume_o),
    .out_effects_o  (out_effects_o),
    .duration_ms_o  (duration_ms_o),
    .measure_o      (measure_o),
    .playing_out_o  (playing_out_o)
  );

endmodule

// ===== hw/rtl/css_div.sv =====
// Restoring divider: HALF_BEAT_MS / divisor, one quotient bit per cycle.
// Depends on css_pkg.
module css_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [css_pkg::BPM_W-1:0] divisor_i,
  output logic                     done_o,
  output logic [css_pkg::DUR_W-1:0] quot_o
);
  import css_pkg::*;

  logic              busy_q;
  logic [DCNT_W-1:0] cnt_q;
  logic [BPM_W-1:0]  rem_q, rem_d;
  logic [BPM_W-1:0]  dsr_q;
  logic [DUR_W-1:0]  dvd_q;
  logic [DUR_W-1:0]  quo_q;
  logic              zero_q;
  logic [BPM_W:0]    trial;
  logic              ge;

  assign trial = {rem_q, dvd_q[DUR_W-1]};
  assign ge    = trial >= {1'b0, dsr_q};
  // remainder stays below the divisor, so BPM_W bits suffice
  assign rem_d = ge ? BPM_W'(trial - {1'b0, dsr_q}) : trial[BPM_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= DCNT_W'(DIV_STEPS - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      dsr_q  <= divisor_i;
      dvd_q  <= DUR_W'(HALF_BEAT_MS);
      zero_q <= (divisor_i == '0);
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[DUR_W-2:0], 1'b0};
      quo_q <= {quo_q[DUR_W-2:0], ge};
    end
  end

  assign done_o = !busy_q;
  // zero tempo saturates
  assign quot_o = zero_q ? DUR_W'(HALF_BEAT_MS) : quo_q;

endmodule

// ===== hw/rtl/css_dp.sv =====
// Datapath: input capture, sequencer state, score memory, divider and output register.
// Depends on css_pkg and css_div.
module css_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        req_type_i,
  input  logic [css_pkg::ANGLE_W-1:0] angle_i,
  input  logic [css_pkg::BPM_W-1:0]   bpm_i,
  input  logic [css_pkg::VOL_W-1:0]   volume_i,
  input  logic [css_pkg::FX_W-1:0]    effects_i,
  input  logic [css_pkg::TIME_W-1:0]  current_time_i,
  input  logic                        playing_in_i,
  input  logic [css_pkg::ENTRY_W-1:0] entry_index_i,
  input  logic [css_pkg::PITCH_W-1:0] entry_pitch_i,
  input  css_pkg::cfg_t               cfg_i,
  input  css_pkg::dp_cmd_t            cmd_i,
  output css_pkg::dp_status_t         st_o,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [1:0]                  kind_o,
  output logic [css_pkg::PITCH_W-1:0] pitch_lead_o,
  output logic [css_pkg::PITCH_W-1:0] pitch_second_o,
  output logic [css_pkg::PITCH_W-1:0] pitch_third_o,
  output logic [css_pkg::VOL_W-1:0]   out_volume_o,
  output logic [css_pkg::FX_W-1:0]    out_effects_o,
  output logic [css_pkg::DUR_W-1:0]   duration_ms_o,
  output logic [css_pkg::MOUT_W-1:0]  measure_o,
  output logic                        playing_out_o
);
  import css_pkg::*;

  // captured beat
  logic                req_q;
  logic [ANGLE_W-1:0]  angle_q;
  logic [BPM_W-1:0]    bpm_q;
  logic [VOL_W-1:0]    vol_q;
  logic [FX_W-1:0]     fx_q;
  logic [TIME_W-1:0]   now_q;
  logic                play_in_q;
  logic [ENTRY_W-1:0]  ent_idx_q;
  logic [PITCH_W-1:0]  ent_pitch_q;

  // sequencer state
  logic [IDX_W-1:0]    idx_q;
  logic [TIME_W-1:0]   nnt_q;
  logic [MEAS_W-1:0]   lm_q;
  logic                mk_q;
  logic [TIME_W-1:0]   lmt_q;
  logic                op_q;
  logic                was_q;

  // per-item results
  kind_e               kind_q, kind_n;
  logic                play_q;
  logic [2:0]          vok_q;
  logic [PITCH_W-1:0]  lead_q, second_q, third_q;

  // output register
  logic                out_valid_q;
  kind_e               okind_q;
  logic [PITCH_W-1:0]  olead_q, osecond_q, othird_q;
  logic [VOL_W-1:0]    ovol_q;
  logic [FX_W-1:0]     ofx_q;
  logic [DUR_W-1:0]    odur_q;
  logic [MOUT_W-1:0]   omeas_q;
  logic                oplay_q;

  // memory
  logic [PITCH_W-1:0]  score_mem_q [SCORE_DEPTH];
  logic [PITCH_W-1:0]  rd_data_q;
  logic [ADDR_W-1:0]   rd_addr;
  logic [ADDR_W-1:0]   wr_addr;
  logic                wr_ok;

  // update evaluation
  logic [IDX_W-1:0]    eff_len;
  logic [MEAS_W-1:0]   cur;
  logic                rise;
  logic [MEAS_W-1:0]   lm_base;
  logic [IDX_W-1:0]    idx_a, idx_b;
  logic [TIME_W-1:0]   nnt_a, nnt_b;
  logic                op_a, op_b, op_c;
  logic                scrub, rel, fire, in_score, note, fin;
  logic                ok_lead, ok_second, ok_third;

  logic                div_done;
  logic [DUR_W-1:0]    quot;

  css_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.eval),
    .divisor_i (bpm_q),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  assign eff_len = (32'(cfg_i.score_length) > SCORE_DEPTH) ? IDX_W'(SCORE_DEPTH)
                                                           : IDX_W'(cfg_i.score_length);

  always_comb begin
    cur     = measure_of_angle(angle_q);
    rise    = play_in_q & ~was_q;
    lm_base = (rise | ~mk_q) ? cur : lm_q;
    idx_a   = rise ? '0 : idx_q;
    nnt_a   = rise ? now_q : nnt_q;
    op_a    = rise ? 1'b0 : op_q;
    scrub   = (cur != lm_base);
    idx_b   = scrub ? IDX_W'(32'(cur) * SLOTS_PER_MEASURE_P) : idx_a;
    op_b    = scrub | op_a;
    // a scrub in this update leaves a zero elapsed time, so no release
    rel     = op_b & ~scrub & ((now_q - lmt_q) > TIME_W'(cfg_i.release_timeout_ms));
    op_c    = op_b & ~rel;
    nnt_b   = rel ? now_q : nnt_a;
    fire    = play_in_q & ~op_c & (now_q >= nnt_b);
    in_score = (IDX_W+1)'(idx_b) < ((IDX_W+1)'(eff_len) + (IDX_W+1)'(LAG_THIRD));
    note    = fire & in_score;
    fin     = fire & ~in_score;
    ok_lead   = idx_b < eff_len;
    ok_second = (32'(idx_b) >= LAG_SECOND) && ((idx_b - IDX_W'(LAG_SECOND)) < eff_len);
    ok_third  = (32'(idx_b) >= LAG_THIRD) && ((idx_b - IDX_W'(LAG_THIRD)) < eff_len);
    if (fin) begin
      kind_n = KIND_END;
    end else if (note) begin
      kind_n = KIND_NOTE;
    end else if (scrub) begin
      kind_n = KIND_SCRUB;
    end else begin
      kind_n = KIND_STATUS;
    end
  end

  always_comb begin
    case (cmd_i.rd_sel)
      VOICE_LEAD:   rd_addr = ADDR_W'(idx_q);
      VOICE_SECOND: rd_addr = ADDR_W'(idx_q - IDX_W'(LAG_SECOND));
      VOICE_THIRD:  rd_addr = ADDR_W'(idx_q - IDX_W'(LAG_THIRD));
      default:      rd_addr = ADDR_W'(idx_q);
    endcase
  end

  assign wr_addr = ADDR_W'(ent_idx_q);
  assign wr_ok   = 32'(ent_idx_q) < SCORE_DEPTH;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_mem && wr_ok) begin
      score_mem_q[wr_addr] <= ent_pitch_q;
    end
    rd_data_q <= score_mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q       <= req_type_i;
      angle_q     <= angle_i;
      bpm_q       <= bpm_i;
      vol_q       <= volume_i;
      fx_q        <= effects_i;
      now_q       <= current_time_i;
      play_in_q   <= playing_in_i;
      ent_idx_q   <= entry_index_i;
      ent_pitch_q <= entry_pitch_i;
    end
    if (cmd_i.eval) begin
      kind_q <= kind_n;
      play_q <= play_in_q & ~fin;
      vok_q  <= {ok_third, ok_second, ok_lead};
    end
    if (cmd_i.cap_lead)   lead_q   <= vok_q[0] ? rd_data_q : '0;
    if (cmd_i.cap_second) second_q <= vok_q[1] ? rd_data_q : '0;
    if (cmd_i.cap_third)  third_q  <= vok_q[2] ? rd_data_q : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      nnt_q <= '0;
      lm_q  <= '0;
      mk_q  <= 1'b0;
      lmt_q <= '0;
      op_q  <= 1'b0;
      was_q <= 1'b0;
    end else if (cmd_i.eval) begin
      was_q <= play_in_q;
      mk_q  <= 1'b1;
      lm_q  <= cur;
      if (scrub) lmt_q <= now_q;
      op_q  <= op_c;
      nnt_q <= nnt_b;
      idx_q <= fin ? '0 : idx_b;
    end else if (cmd_i.commit) begin
      idx_q <= idx_q + 1'b1;
      nnt_q <= nnt_q + TIME_W'(quot);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      okind_q <= kind_q;
      omeas_q <= measure_of_index(idx_q);
      oplay_q <= play_q;
      if (kind_q == KIND_NOTE) begin
        olead_q   <= lead_q;
        osecond_q <= second_q;
        othird_q  <= third_q;
        ovol_q    <= vol_q;
        ofx_q     <= fx_q;
        odur_q    <= quot;
      end else begin
        olead_q   <= '0;
        osecond_q <= '0;
        othird_q  <= '0;
        ovol_q    <= '0;
        ofx_q     <= '0;
        odur_q    <= '0;
      end
    end
  end

  assign st_o.is_write = req_q;
  assign st_o.is_note  = note;
  assign st_o.div_done = div_done;
  assign st_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign kind_o         = okind_q;
  assign pitch_lead_o   = olead_q;
  assign pitch_second_o = osecond_q;
  assign pitch_third_o  = othird_q;
  assign out_volume_o   = ovol_q;
  assign out_effects_o  = ofx_q;
  assign duration_ms_o  = odur_q;
  assign measure_o      = omeas_q;
  assign playing_out_o  = oplay_q;

endmodule

// ===== hw/rtl/css_ctrl.sv =====
// Controller state machine: sequences capture, evaluation, voice reads,
// divider wait and result hand-off. Depends on css_pkg.
module css_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  css_pkg::dp_status_t st_i,
  output css_pkg::dp_cmd_t    cmd_o
);
  import css_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.rd_sel = VOICE_LEAD;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (st_i.is_write) begin
          cmd_o.wr_mem = 1'b1;
          state_d      = ST_IDLE;
        end else begin
          cmd_o.eval = 1'b1;
          state_d    = st_i.is_note ? ST_RD_LEAD : ST_EMIT;
        end
      end
      ST_RD_LEAD: begin
        cmd_o.rd_sel = VOICE_LEAD;
        state_d      = ST_RD_SECOND;
      end
      ST_RD_SECOND: begin
        cmd_o.rd_sel   = VOICE_SECOND;
        cmd_o.cap_lead = 1'b1;
        state_d        = ST_RD_THIRD;
      end
      ST_RD_THIRD: begin
        cmd_o.rd_sel     = VOICE_THIRD;
        cmd_o.cap_second = 1'b1;
        state_d          = ST_RD_LAST;
      end
      ST_RD_LAST: begin
        cmd_o.cap_third = 1'b1;
        state_d         = ST_WAIT_DIV;
      end
      ST_WAIT_DIV: begin
        if (st_i.div_done) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (st_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  a_load_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> st_i.out_free)
    else $error("result loaded over an untaken beat");

  a_accept_decodes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_DECODE))
    else $error("accepted beat not decoded");

  a_div_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WAIT_DIV && !st_i.div_done) |=> (state_q == ST_WAIT_DIV))
    else $error("left divider wait early");

  a_commit_then_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> (state_q == ST_EMIT))
    else $error("note commit not followed by emit");

endmodule

// ===== tb/sv/canon_score_sequencer_with_scrub_tb.sv =====
// Self-checking testbench for canon_score_sequencer_with_scrub.
// Queue-fed driver and clocked monitor around an in-bench predictor of the canon sequencer;
// depends on css_pkg and the RTL of the block only.
module canon_score_sequencer_with_scrub_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import css_pkg::*;

  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_WRITE  = 1'b1;
  localparam logic [APB_AW-1:0] ADDR_SCORE_LEN = 3'h0;
  localparam logic [APB_AW-1:0] ADDR_RELEASE   = 3'h4;
  localparam int CYCLE_LIMIT  = 400_000;
  localparam int SETTLE       = 40;
  localparam int PHASE_BEATS  = 125;
  localparam int NUM_PHASES   = 6;

  typedef struct packed {
    logic                req_type;
    logic [ANGLE_W-1:0]  angle;
    logic [BPM_W-1:0]    bpm;
    logic [VOL_W-1:0]    volume;
    logic [FX_W-1:0]     effects;
    logic [TIME_W-1:0]   now_ms;
    logic                playing;
    logic [ENTRY_W-1:0]  slot;
    logic [PITCH_W-1:0]  pitch;
  } beat_t;

  typedef struct packed {
    kind_e               kind;
    logic [PITCH_W-1:0]  lead;
    logic [PITCH_W-1:0]  second;
    logic [PITCH_W-1:0]  third;
    logic [VOL_W-1:0]    vol;
    logic [FX_W-1:0]     fx;
    logic [DUR_W-1:0]    dur;
    logic [MOUT_W-1:0]   measure;
    logic                playing;
  } cue_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic                req_type_i;
  logic [ANGLE_W-1:0]  angle_i;
  logic [BPM_W-1:0]    bpm_i;
  logic [VOL_W-1:0]    volume_i;
  logic [FX_W-1:0]     effects_i;
  logic [TIME_W-1:0]   current_time_i;
  logic                playing_in_i;
  logic [ENTRY_W-1:0]  entry_index_i;
  logic [PITCH_W-1:0]  entry_pitch_i;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [1:0]          kind_o;
  logic [PITCH_W-1:0]  pitch_lead_o;
  logic [PITCH_W-1:0]  pitch_second_o;
  logic [PITCH_W-1:0]  pitch_third_o;
  logic [VOL_W-1:0]    out_volume_o;
  logic [FX_W-1:0]     out_effects_o;
  logic [DUR_W-1:0]    duration_ms_o;
  logic [MOUT_W-1:0]   measure_o;
  logic                playing_out_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [APB_AW-1:0]   paddr = '0;
  logic [APB_DW-1:0]   pwdata = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  beat_t beat = '0;

  assign req_type_i     = beat.req_type;
  assign angle_i        = beat.angle;
  assign bpm_i          = beat.bpm;
  assign volume_i       = beat.volume;
  assign effects_i      = beat.effects;
  assign current_time_i = beat.now_ms;
  assign playing_in_i   = beat.playing;
  assign entry_index_i  = beat.slot;
  assign entry_pitch_i  = beat.pitch;

  canon_score_sequencer_with_scrub DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .angle_i        (angle_i),
    .bpm_i          (bpm_i),
    .volume_i       (volume_i),
    .effects_i      (effects_i),
    .current_time_i (current_time_i),
    .playing_in_i   (playing_in_i),
    .entry_index_i  (entry_index_i),
    .entry_pitch_i  (entry_pitch_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .pitch_lead_o   (pitch_lead_o),
    .pitch_second_o (pitch_second_o),
    .pitch_third_o  (pitch_third_o),
    .out_volume_o   (out_volume_o),
    .out_effects_o  (out_effects_o),
    .duration_ms_o  (duration_ms_o),
    .measure_o      (measure_o),
    .playing_out_o  (playing_out_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Sequencer state as the predictor sees it
  logic [PITCH_W-1:0] score_mem [SCORE_DEPTH];
  int unsigned        cursor = 0;
  logic [TIME_W-1:0]  due_ms = '0;
  logic [TIME_W-1:0]  scrub_ms = '0;
  int unsigned        held_meas = 0;
  bit                 meas_seen = 1'b0;
  bit                 scrubbing = 1'b0;
  bit                 prev_playing = 1'b0;
  int unsigned        cfg_len = 0;
  logic [TMO_W-1:0]   cfg_hold = TMO_W'(TIMEOUT_RST);

  beat_t pend_q [$];
  cue_t  cue_q [$];
  cue_t  head;

  int n_queued = 0, n_beats = 0, n_results = 0, n_fail = 0, n_cycles = 0;
  int n_notes = 0, n_scrubs = 0, n_ends = 0, n_settings = 0;

  // Stimulus generator state
  logic [TIME_W-1:0]  gen_ms = '0;
  int unsigned        ph_len = 0;
  int unsigned        ph_hold = 0;
  bit [SCORE_DEPTH-1:0] written = '0;

  function automatic int unsigned eff_len();
    return (cfg_len > SCORE_DEPTH) ? SCORE_DEPTH : cfg_len;
  endfunction

  function automatic logic [PITCH_W-1:0] voice_at(input int pos);
    if (pos < 0 || pos >= int'(eff_len())) return '0;
    return score_mem[pos];
  endfunction

  // Advance the sequencer by one accepted beat; an update queues its result
  function automatic void play_step(input beat_t b);
    cue_t              c;
    int unsigned       knob, dur, m;
    bit                run;
    logic [TIME_W-1:0] gap;
    if (b.req_type == REQ_WRITE) begin
      score_mem[b.slot] = b.pitch;
      return;
    end
    c = '0;
    c.kind = KIND_STATUS;
    run = b.playing;
    knob = b.angle / DEG_PER_MEASURE;
    if (knob > MEASURE_COUNT - 1) knob = MEASURE_COUNT - 1;
    if (run && !prev_playing) begin
      cursor = 0;
      due_ms = b.now_ms;
      held_meas = knob;
      meas_seen = 1'b1;
      scrubbing = 1'b0;
    end
    prev_playing = run;
    if (!meas_seen) begin
      held_meas = knob;
      meas_seen = 1'b1;
    end
    if (knob != held_meas) begin
      scrubbing = 1'b1;
      scrub_ms = b.now_ms;
      held_meas = knob;
      cursor = knob * SLOTS_PER_MEASURE_P;
      c.kind = KIND_SCRUB;
      n_scrubs++;
    end
    // wrapped difference, so a release can span the 32-bit roll-over
    gap = b.now_ms - scrub_ms;
    if (scrubbing && gap > TIME_W'(cfg_hold)) begin
      scrubbing = 1'b0;
      due_ms = b.now_ms;
    end
    if (run && !scrubbing && b.now_ms >= due_ms) begin
      if (cursor < eff_len() + LAG_THIRD) begin
        dur = (b.bpm == 0) ? HALF_BEAT_MS : HALF_BEAT_MS / b.bpm;
        c.kind   = KIND_NOTE;
        c.lead   = voice_at(int'(cursor));
        c.second = voice_at(int'(cursor) - LAG_SECOND);
        c.third  = voice_at(int'(cursor) - LAG_THIRD);
        c.vol    = b.volume;
        c.fx     = b.effects;
        c.dur    = DUR_W'(dur);
        due_ms   = due_ms + TIME_W'(dur);
        cursor++;
        n_notes++;
      end else begin
        run = 1'b0;
        cursor = 0;
        c.kind = KIND_END;
        n_ends++;
      end
    end
    m = cursor / SLOTS_PER_MEASURE_P + 1;
    if (m > MEASURE_COUNT) m = MEASURE_COUNT;
    c.measure = MOUT_W'(m);
    c.playing = run;
    cue_q.push_back(c);
  endfunction

  function automatic void cmp(input string field, input logic [31:0] want,
                              input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      n_fail++;
    end
  endfunction

  // Driver: present the next pending beat, hold it until taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        play_step(beat);
        n_beats++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pend_q.size() != 0 &&
            ((n_beats >= 300 && n_beats < 450) || $urandom_range(0, 99) >= 11)) begin
          beat <= pend_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result beat against the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        n_results++;
        if (cue_q.size() == 0) begin
          $error("result beat with nothing expected (kind %0d)", kind_o);
          n_fail++;
        end else begin
          head = cue_q.pop_front();
          cmp("kind", head.kind, kind_o);
          cmp("pitch_lead", head.lead, pitch_lead_o);
          cmp("pitch_second", head.second, pitch_second_o);
          cmp("pitch_third", head.third, pitch_third_o);
          cmp("out_volume", head.vol, out_volume_o);
          cmp("out_effects", head.fx, out_effects_o);
          cmp("duration_ms", head.dur, duration_ms_o);
          cmp("measure", head.measure, measure_o);
          cmp("playing_out", head.playing, playing_out_o);
        end
      end
      out_ready_i <= (n_results >= 250 && n_results < 400) || $urandom_range(0, 99) >= 11;
    end
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("Cycle limit reached with %0d results outstanding", cue_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic void push_update(input int unsigned angle, input int unsigned bpm,
                                      input int unsigned vol, input int unsigned fx,
                                      input bit playing);
    beat_t b;
    b = '0;
    b.req_type = REQ_UPDATE;
    b.angle    = ANGLE_W'(angle);
    b.bpm      = BPM_W'(bpm);
    b.volume   = VOL_W'(vol);
    b.effects  = FX_W'(fx);
    b.now_ms   = gen_ms;
    b.playing  = playing;
    b.slot     = ENTRY_W'($urandom);
    b.pitch    = PITCH_W'($urandom);
    pend_q.push_back(b);
    n_queued++;
  endfunction

  function automatic void push_write(input int unsigned slot, input int unsigned pitch);
    beat_t b;
    b = '0;
    b.req_type = REQ_WRITE;
    b.angle    = ANGLE_W'($urandom);
    b.bpm      = BPM_W'($urandom_range(1, 511));
    b.now_ms   = $urandom;
    b.playing  = 1'($urandom_range(0, 1));
    b.slot     = ENTRY_W'(slot);
    b.pitch    = PITCH_W'(pitch);
    written[slot] = 1'b1;
    pend_q.push_back(b);
    n_queued++;
  endfunction

  // Slots below the score length must hold a pitch before any note reads them
  function automatic void fill_score(input int unsigned upto);
    for (int s = 0; s < upto && s < SCORE_DEPTH; s++) begin
      if (!written[s]) push_write(s, $urandom_range(0, 127));
    end
  endfunction

  function automatic int unsigned knob_for(input int unsigned meas);
    if (meas >= MEASURE_COUNT - 1) return $urandom_range((MEASURE_COUNT - 1) * DEG_PER_MEASURE, 511);
    return meas * DEG_PER_MEASURE + $urandom_range(0, DEG_PER_MEASURE - 1);
  endfunction

  function automatic void tick(input int unsigned dur);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8)       gen_ms += 0;
    else if (r < 16) gen_ms += (dur > 0) ? dur - 1 : 0;
    else if (r < 70) gen_ms += dur;
    else if (r < 92) gen_ms += dur + $urandom_range(0, dur);
    else             gen_ms += $urandom_range(0, 1 << 20);
  endfunction

  function automatic int unsigned pick_bpm();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return 1;
    if (r < 16) return 511;
    return $urandom_range(1, 511);
  endfunction

  // One song: restart from the top, play through with knob jitter, scrubs,
  // stray score writes and the odd pause, running on past the end
  function automatic void run_song();
    int unsigned bpm, dur, meas, n;
    bpm  = pick_bpm();
    dur  = HALF_BEAT_MS / bpm;
    meas = $urandom_range(0, MEASURE_COUNT - 1);
    gen_ms += $urandom_range(0, 1000);
    push_update(knob_for(meas), bpm, $urandom_range(0, 255), $urandom_range(0, 255), 1'b0);
    gen_ms += $urandom_range(0, dur);
    push_update(knob_for(meas), bpm, $urandom_range(0, 255), $urandom_range(0, 255), 1'b1);
    n = ph_len + LAG_THIRD + $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 4)
        push_write($urandom_range(0, SCORE_DEPTH - 1), $urandom_range(0, 127));
      if ($urandom_range(0, 99) < 3) begin
        bpm = pick_bpm();
        dur = HALF_BEAT_MS / bpm;
      end
      if ($urandom_range(0, 99) < 3)
        push_update(knob_for(meas), bpm, $urandom_range(0, 255), $urandom_range(0, 255), 1'b0);
      if ($urandom_range(0, 99) < 6) begin
        meas = $urandom_range(0, MEASURE_COUNT - 1);
        gen_ms += $urandom_range(0, dur);
        push_update(knob_for(meas), bpm, $urandom_range(0, 255), $urandom_range(0, 255), 1'b1);
        // walk the clock towards the release point
        repeat ($urandom_range(1, 3)) begin
          gen_ms += ph_hold / 2 + $urandom_range(0, 1);
          push_update(knob_for(meas), bpm, $urandom_range(0, 255),
                      $urandom_range(0, 255), 1'b1);
        end
      end
      tick(dur);
      push_update(knob_for(meas), bpm, $urandom_range(0, 255), $urandom_range(0, 255), 1'b1);
    end
  endfunction

  function automatic void noise_burst();
    repeat (8) begin
      if ($urandom_range(0, 1)) begin
        push_write($urandom_range(0, SCORE_DEPTH - 1), $urandom_range(0, 127));
      end else begin
        gen_ms = $urandom;
        push_update($urandom_range(0, 511), $urandom_range(1, 511), $urandom_range(0, 255),
                    $urandom_range(0, 255), 1'($urandom_range(0, 1)));
      end
    end
  endfunction

  task automatic reg_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(input int unsigned len, input int unsigned hold);
    reg_write(ADDR_SCORE_LEN, APB_DW'(len));
    reg_write(ADDR_RELEASE, APB_DW'(hold));
    cfg_len  = len;
    cfg_hold = TMO_W'(hold);
    ph_len   = len;
    ph_hold  = hold;
    n_settings++;
  endtask

  // Let every queued beat drain and the last result land, then allow the
  // block to finish any trailing score write
  task automatic wait_drained();
    while (n_beats != n_queued || cue_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  int unsigned phase_len  [NUM_PHASES] = '{64, 5, 16, 0, 33, 64};
  int unsigned phase_hold [NUM_PHASES] = '{300, 65535, 0, 1000, 50, 20};

  initial begin
    int start;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: two-slot score, instant release
    set_config(2, 0);
    push_write(0, 127);
    push_write(1, 0);
    gen_ms = 0;
    push_update(0, 1, 0, 0, 1'b0);             // status only, first measure seen
    push_update(0, 511, 255, 255, 1'b1);       // restart, first note, voices behind are off-score
    gen_ms = 10;
    push_update(44, 511, 0, 0, 1'b1);          // note not yet due
    gen_ms = 58;
    push_update(511, 511, 1, 1, 1'b1);         // scrub to last measure, no note in same update
    gen_ms = 59;
    push_update(511, 511, 1, 1, 1'b1);         // released beyond the score: all-off
    gen_ms = 100;
    push_update(511, 1, 0, 0, 1'b0);
    gen_ms = 32'hFFFF_FFF0;
    push_update(90, 1, 128, 64, 1'b1);         // restart near roll-over, longest note
    gen_ms = 32'hFFFF_FFFF;
    push_update(134, 1, 1, 2, 1'b1);           // due time wrapped low, plain compare fires
    gen_ms = 5;
    push_update(90, 1, 3, 4, 1'b1);
    gen_ms = 100;
    push_update(89, 1, 5, 6, 1'b1);            // scrub back to measure two
    push_update(45, 1, 7, 8, 1'b1);            // zero gap does not release
    push_write(63, 127);
    push_write(0, 0);
    gen_ms = 101;
    push_update(88, 300, 255, 0, 1'b1);        // released, note outside the score
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_config(phase_len[p], phase_hold[p]);
      fill_score(phase_len[p]);
      gen_ms = $urandom;
      start = n_queued;
      while (n_queued - start < PHASE_BEATS) begin
        if ($urandom_range(0, 99) < 12) noise_burst();
        else run_song();
      end
      wait_drained();
    end

    $display("Covered %0d beats and %0d results over %0d register settings:",
             n_beats, n_results, n_settings);
    $display("  %0d notes, %0d scrubs, %0d song ends, %0d mismatches",
             n_notes, n_scrubs, n_ends, n_fail);
    if (n_fail == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
